FILE: design/delayed_load_register_file_top_macros.svh
// Assertion macros for the delayed-load register file checker.
// Expects clk and arst_n in the scope of the user.
`ifndef DELAYED_LOAD_REGISTER_FILE_TOP_MACROS_SVH
`define DELAYED_LOAD_REGISTER_FILE_TOP_MACROS_SVH

// same-cycle implication
`define DLRF_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DLRF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/dlrf_pkg.sv
// Shared types and constants for the delayed-load register file.
// No dependencies; used by the top level and its checker.
package dlrf_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int REG_COUNT   = 32;

	localparam int IDX_W  = 5;
	localparam int DATA_W = 32;
	localparam int DLY_W  = 3;
	localparam int ADDR_W = $clog2(REG_COUNT);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

	typedef logic [IDX_W-1:0]  reg_idx_t;
	typedef logic [DATA_W-1:0] word_t;
	typedef logic [DLY_W-1:0]  dly_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	localparam dly_t LOAD_DELAY_RESET = dly_t'(1);

	typedef struct packed {
		reg_idx_t read_index_a;
		reg_idx_t read_index_b;
		logic     load_valid;
		reg_idx_t load_index;
		word_t    load_value;
	} in_word_t;

	typedef struct packed {
		word_t read_value_a;
		word_t read_value_b;
		logic  queue_overflow;
	} out_word_t;

	// register exists and is not the hardwired zero
	function automatic logic is_live_reg(reg_idx_t idx);
		return (idx != '0) && (32'(idx) < REG_COUNT);
	endfunction

endpackage

FILE: design/delayed_load_register_file_top.sv
// Delayed-load register file, top level.
// Depends on dlrf_pkg.
//
// A general register file whose loads land late, as in a load delay slot.
// Each accepted in_data word is one instruction cycle: both read ports return
// the register contents as they stood before that cycle, an optional load is
// queued with the delay held in the configuration register (cfg_wr_en /
// cfg_wr_data, reset value 1), and then every pending load ticks; a load whose
// counter was zero retires into the bank, oldest first. A load arriving while
// QUEUE_DEPTH loads are pending is dropped and flagged in queue_overflow.
// Register zero always reads zero. The block takes one word per clock while the
// output is not stalled; the result leaves on out_data by way of the working
// stage and then the output register, paced by the output handshake.
// The bank is a two-read, one-write memory with registered read data, so
// several loads retiring in one cycle go through a small write buffer that
// drains one entry per clock into the bank; reads see that buffer by
// forwarding. The bank is cleared at reset by per-entry valid bits: there is
// no clearing pass and no start-up wait.
module delayed_load_register_file_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  dlrf_pkg::dly_t       cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  dlrf_pkg::in_word_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output dlrf_pkg::out_word_t  out_data
);

	// configuration
	dlrf_pkg::dly_t load_delay_q;

	// working stage
	logic               valid_s1;
	dlrf_pkg::in_word_t item_s1;
	dlrf_pkg::word_t    rd_a_s1;
	dlrf_pkg::word_t    rd_b_s1;

	// pending load queue, entry 0 is the oldest
	dlrf_pkg::reg_idx_t pend_idx_q  [dlrf_pkg::QUEUE_DEPTH];
	dlrf_pkg::word_t    pend_data_q [dlrf_pkg::QUEUE_DEPTH];
	dlrf_pkg::dly_t     pend_dly_q  [dlrf_pkg::QUEUE_DEPTH];
	dlrf_pkg::cnt_t     pend_cnt_q;
	dlrf_pkg::reg_idx_t pend_idx_d  [dlrf_pkg::QUEUE_DEPTH];
	dlrf_pkg::word_t    pend_data_d [dlrf_pkg::QUEUE_DEPTH];
	dlrf_pkg::dly_t     pend_dly_d  [dlrf_pkg::QUEUE_DEPTH];
	dlrf_pkg::cnt_t     pend_cnt_d;

	// write buffer of retired loads not yet in the bank, entry 0 is the oldest
	dlrf_pkg::reg_idx_t wb_idx_q  [dlrf_pkg::QUEUE_DEPTH];
	dlrf_pkg::word_t    wb_data_q [dlrf_pkg::QUEUE_DEPTH];
	dlrf_pkg::cnt_t     wb_cnt_q;
	dlrf_pkg::reg_idx_t wb_idx_d  [dlrf_pkg::QUEUE_DEPTH];
	dlrf_pkg::word_t    wb_data_d [dlrf_pkg::QUEUE_DEPTH];
	dlrf_pkg::cnt_t     wb_cnt_d;

	// register bank
	dlrf_pkg::word_t                bank_q [dlrf_pkg::REG_COUNT];
	logic [dlrf_pkg::REG_COUNT-1:0] bank_vld_q;

	// output register
	logic                out_valid_q;
	dlrf_pkg::out_word_t out_q;

	logic            fire;
	logic            accept;
	logic            drain;
	dlrf_pkg::addr_t rd_addr_a;
	dlrf_pkg::addr_t rd_addr_b;
	dlrf_pkg::addr_t drain_addr;
	dlrf_pkg::word_t fwd_a;
	dlrf_pkg::word_t fwd_b;
	logic            overflow;

	// The working stage completes whenever the output register is free.
	assign fire     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;
	assign accept   = in_valid && in_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Buffer drains one entry per clock, independent of traffic.
	assign drain      = (wb_cnt_q != '0);
	assign drain_addr = wb_idx_q[0][dlrf_pkg::ADDR_W-1:0];

	// Bank is re-read every cycle at the indexes of the word that will sit in
	// the working stage, so a stalled word still sees buffer drains.
	assign rd_addr_a = accept ? in_data.read_index_a[dlrf_pkg::ADDR_W-1:0]
	                          : item_s1.read_index_a[dlrf_pkg::ADDR_W-1:0];
	assign rd_addr_b = accept ? in_data.read_index_b[dlrf_pkg::ADDR_W-1:0]
	                          : item_s1.read_index_b[dlrf_pkg::ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (drain) begin
			bank_q[drain_addr] <= wb_data_q[0];
		end
		// write-through bypass for the entry being drained
		if (drain && (drain_addr == rd_addr_a)) begin
			rd_a_s1 <= wb_data_q[0];
		end else begin
			rd_a_s1 <= bank_vld_q[rd_addr_a] ? bank_q[rd_addr_a] : '0;
		end
		if (drain && (drain_addr == rd_addr_b)) begin
			rd_b_s1 <= wb_data_q[0];
		end else begin
			rd_b_s1 <= bank_vld_q[rd_addr_b] ? bank_q[rd_addr_b] : '0;
		end
	end

	// Read value = newest buffered write to that register, else the bank.
	always_comb begin
		fwd_a = rd_a_s1;
		fwd_b = rd_b_s1;
		for (int i = 0; i < dlrf_pkg::QUEUE_DEPTH; i++) begin
			if (dlrf_pkg::cnt_t'(i) < wb_cnt_q) begin
				if (wb_idx_q[i] == item_s1.read_index_a) begin
					fwd_a = wb_data_q[i];
				end
				if (wb_idx_q[i] == item_s1.read_index_b) begin
					fwd_b = wb_data_q[i];
				end
			end
		end
		if (!dlrf_pkg::is_live_reg(item_s1.read_index_a)) begin
			fwd_a = '0;
		end
		if (!dlrf_pkg::is_live_reg(item_s1.read_index_b)) begin
			fwd_b = '0;
		end
	end

	// Enqueue, then tick: retiring entries append to the write buffer in
	// queue order, survivors compact toward entry 0.
	always_comb begin
		dlrf_pkg::reg_idx_t e_idx  [dlrf_pkg::QUEUE_DEPTH];
		dlrf_pkg::word_t    e_data [dlrf_pkg::QUEUE_DEPTH];
		dlrf_pkg::dly_t     e_dly  [dlrf_pkg::QUEUE_DEPTH];
		dlrf_pkg::cnt_t     e_cnt;
		dlrf_pkg::cnt_t     kept;
		dlrf_pkg::cnt_t     w_cnt;

		e_idx    = pend_idx_q;
		e_data   = pend_data_q;
		e_dly    = pend_dly_q;
		e_cnt    = pend_cnt_q;
		overflow = 1'b0;
		if (item_s1.load_valid) begin
			if (pend_cnt_q == dlrf_pkg::cnt_t'(dlrf_pkg::QUEUE_DEPTH)) begin
				overflow = 1'b1;
			end else begin
				for (int i = 0; i < dlrf_pkg::QUEUE_DEPTH; i++) begin
					if (dlrf_pkg::cnt_t'(i) == pend_cnt_q) begin
						e_idx[i]  = item_s1.load_index;
						e_data[i] = item_s1.load_value;
						e_dly[i]  = load_delay_q;
					end
				end
				e_cnt = pend_cnt_q + dlrf_pkg::cnt_t'(1);
			end
		end

		for (int i = 0; i < dlrf_pkg::QUEUE_DEPTH; i++) begin
			if (drain) begin
				wb_idx_d[i]  = wb_idx_q[(i + 1 < dlrf_pkg::QUEUE_DEPTH) ? i + 1 : i];
				wb_data_d[i] = wb_data_q[(i + 1 < dlrf_pkg::QUEUE_DEPTH) ? i + 1 : i];
			end else begin
				wb_idx_d[i]  = wb_idx_q[i];
				wb_data_d[i] = wb_data_q[i];
			end
		end
		w_cnt = wb_cnt_q - dlrf_pkg::cnt_t'(drain);

		pend_idx_d  = pend_idx_q;
		pend_data_d = pend_data_q;
		pend_dly_d  = pend_dly_q;
		pend_cnt_d  = pend_cnt_q;
		kept        = '0;
		if (fire) begin
			for (int i = 0; i < dlrf_pkg::QUEUE_DEPTH; i++) begin
				if (dlrf_pkg::cnt_t'(i) < e_cnt) begin
					if (e_dly[i] == '0) begin
						// writes to register zero or past the bank just vanish
						if (dlrf_pkg::is_live_reg(e_idx[i])) begin
							for (int j = 0; j < dlrf_pkg::QUEUE_DEPTH; j++) begin
								if (dlrf_pkg::cnt_t'(j) == w_cnt) begin
									wb_idx_d[j]  = e_idx[i];
									wb_data_d[j] = e_data[i];
								end
							end
							w_cnt = w_cnt + dlrf_pkg::cnt_t'(1);
						end
					end else begin
						for (int j = 0; j < dlrf_pkg::QUEUE_DEPTH; j++) begin
							if (dlrf_pkg::cnt_t'(j) == kept) begin
								pend_idx_d[j]  = e_idx[i];
								pend_data_d[j] = e_data[i];
								pend_dly_d[j]  = e_dly[i] - dlrf_pkg::dly_t'(1);
							end
						end
						kept = kept + dlrf_pkg::cnt_t'(1);
					end
				end
			end
			pend_cnt_d = kept;
		end
		wb_cnt_d = w_cnt;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_delay_q <= dlrf_pkg::LOAD_DELAY_RESET;
			valid_s1     <= 1'b0;
			pend_cnt_q   <= '0;
			wb_cnt_q     <= '0;
			out_valid_q  <= 1'b0;
			bank_vld_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				load_delay_q <= cfg_wr_data;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			pend_cnt_q <= pend_cnt_d;
			wb_cnt_q   <= wb_cnt_d;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (drain) begin
				bank_vld_q[drain_addr] <= 1'b1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
		pend_idx_q  <= pend_idx_d;
		pend_data_q <= pend_data_d;
		pend_dly_q  <= pend_dly_d;
		wb_idx_q    <= wb_idx_d;
		wb_data_q   <= wb_data_d;
		if (fire) begin
			out_q.read_value_a   <= fwd_a;
			out_q.read_value_b   <= fwd_b;
			out_q.queue_overflow <= overflow;
		end
	end

endmodule

FILE: design/dlrf_checker.sv
// Port-level checker for the delayed-load register file, bound to the top.
// Depends on dlrf_pkg and delayed_load_register_file_top_macros.svh.
`include "delayed_load_register_file_top_macros.svh"

module dlrf_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input dlrf_pkg::out_word_t out_data
);

	// stalled result word holds
	`DLRF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "out word changed under stall")

	// input only backs up behind a stalled output word
	`DLRF_ASSERT_IMPL(a_stall_cause, !in_ready, out_valid && !out_ready, "in_ready low without output stall")

	// accepted word reaches the output once the sink is ready
	`DLRF_ASSERT_NEXT(a_progress, (in_valid && in_ready) ##1 out_ready, out_valid, "accepted word did not advance")

endmodule

bind delayed_load_register_file_top dlrf_checker u_dlrf_checker (.*);
